// ----- rtl/qvr_pkg.sv -----
`timescale 1ns / 1ps

package qvr_pkg;

  // Fraction bits of the quaternion components (Q2.14 by default).
  localparam int FRAC_BITS = 14;
  // The sandwich product carries two quaternion scales.
  localparam int SHIFT     = 2 * FRAC_BITS;

  localparam int IN_W   = 16;
  localparam int OUT_W  = 16;
  // q * v products, then sums of three products.
  localparam int PROD_W = 2 * IN_W;
  localparam int PSUM_W = PROD_W + 2;
  // p * conj(q) products, then sums of four products.
  localparam int RPRD_W = PSUM_W + IN_W;
  localparam int RSUM_W = RPRD_W + 2;
  // Rounded value before saturation.
  localparam int RND_W  = RSUM_W + 1 - SHIFT;

  typedef logic signed [IN_W-1:0]   comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PSUM_W-1:0] psum_t;
  typedef logic signed [RPRD_W-1:0] rprd_t;
  typedef logic signed [RSUM_W-1:0] rsum_t;
  typedef logic signed [RND_W-1:0]  rnd_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  localparam rnd_t OUT_MAX = rnd_t'(2 ** (OUT_W - 1) - 1);
  localparam rnd_t OUT_MIN = -rnd_t'(2 ** (OUT_W - 1));

endpackage

// ----- rtl/quaternion_vector_rotate.sv -----
`timescale 1ns / 1ps

// Channel | Signals                                  | Direction
// --------+------------------------------------------+----------
// in      | in_valid, in_stall, quat_w..z, vec_x..z  | into block
// out     | out_valid, out_stall, out_x..z, clipped  | out of block
//
// A transaction enters every cycle while in_stall is low. Its result passes
// through stages 1-4 into the output register. There are five register stages:
// two multiply stages, two adder stages, and the output register behind the
// round and saturate logic. The pipeline advances as a whole whenever the
// output register is empty or being taken, so in_stall simply follows the
// downstream stall while a result waits. rst (synchronous, active high)
// clears every valid bit; payload registers are not reset.

module quaternion_vector_rotate (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qvr_pkg::comp_t      quat_w,
  input  qvr_pkg::comp_t      quat_x,
  input  qvr_pkg::comp_t      quat_y,
  input  qvr_pkg::comp_t      quat_z,
  input  qvr_pkg::comp_t      vec_x,
  input  qvr_pkg::comp_t      vec_y,
  input  qvr_pkg::comp_t      vec_z,
  output logic                out_valid,
  input  logic                out_stall,
  output qvr_pkg::comp_t      out_x,
  output qvr_pkg::comp_t      out_y,
  output qvr_pkg::comp_t      out_z,
  output logic                clipped
);
  import qvr_pkg::*;

  // Every stage moves when the output register can accept new data.
  logic advance;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  // Valid bits that travel alongside the four inner stages.
  logic [3:0] valid;

  // Stage 1: the twelve products of q and the pure vector v.
  quat_t q1;
  prod_t qx_vx, qy_vy, qz_vz;
  prod_t qw_vx, qy_vz, qz_vy;
  prod_t qw_vy, qx_vz, qz_vx;
  prod_t qw_vz, qx_vy, qy_vx;

  // Stage 2: p = q * (0, v).
  quat_t q2;
  psum_t pw, px, py, pz;

  // Stage 3: products of p and conj(q); the w part of the result is not
  // needed, so only twelve products are formed.
  rprd_t pw_qx, px_qw, py_qz, pz_qy;
  rprd_t pw_qy, px_qz, py_qw, pz_qx;
  rprd_t pw_qz, px_qy, py_qx, pz_qw;

  // Stage 4: the vector part of r = p * conj(q), scaled by 2^SHIFT.
  rsum_t rx, ry, rz;

  // Round to nearest with ties toward plus infinity: add one half, then an
  // arithmetic shift floors the value.
  localparam rsum_t HALF = rsum_t'(1) <<< (SHIFT - 1);

  logic [RSUM_W:0] rx_bias, ry_bias, rz_bias;
  rnd_t            rx_rnd, ry_rnd, rz_rnd;
  logic            sat_x, sat_y, sat_z;
  comp_t           res_x, res_y, res_z;

  assign rx_bias = (RSUM_W + 1)'(signed'(rx)) + (RSUM_W + 1)'(HALF);
  assign ry_bias = (RSUM_W + 1)'(signed'(ry)) + (RSUM_W + 1)'(HALF);
  assign rz_bias = (RSUM_W + 1)'(signed'(rz)) + (RSUM_W + 1)'(HALF);

  assign rx_rnd = rnd_t'(signed'(rx_bias) >>> SHIFT);
  assign ry_rnd = rnd_t'(signed'(ry_bias) >>> SHIFT);
  assign rz_rnd = rnd_t'(signed'(rz_bias) >>> SHIFT);

  always_comb begin
    sat_x = 1'b0;
    sat_y = 1'b0;
    sat_z = 1'b0;
    res_x = comp_t'(rx_rnd);
    res_y = comp_t'(ry_rnd);
    res_z = comp_t'(rz_rnd);
    if (rx_rnd > OUT_MAX) begin
      res_x = comp_t'(OUT_MAX);
      sat_x = 1'b1;
    end else if (rx_rnd < OUT_MIN) begin
      res_x = comp_t'(OUT_MIN);
      sat_x = 1'b1;
    end
    if (ry_rnd > OUT_MAX) begin
      res_y = comp_t'(OUT_MAX);
      sat_y = 1'b1;
    end else if (ry_rnd < OUT_MIN) begin
      res_y = comp_t'(OUT_MIN);
      sat_y = 1'b1;
    end
    if (rz_rnd > OUT_MAX) begin
      res_z = comp_t'(OUT_MAX);
      sat_z = 1'b1;
    end else if (rz_rnd < OUT_MIN) begin
      res_z = comp_t'(OUT_MIN);
      sat_z = 1'b1;
    end
  end

  // Control: valid bits shift with the data and are cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      valid     <= {valid[2:0], in_valid};
      out_valid <= valid[3];
    end
  end

  // Datapath: the whole pipeline holds while the output is stalled, so a
  // waiting result and everything behind it stay put.
  always_ff @(posedge clk) begin
    if (advance) begin
      // Stage 1
      q1    <= '{w: quat_w, x: quat_x, y: quat_y, z: quat_z};
      qx_vx <= prod_t'(quat_x) * prod_t'(vec_x);
      qy_vy <= prod_t'(quat_y) * prod_t'(vec_y);
      qz_vz <= prod_t'(quat_z) * prod_t'(vec_z);
      qw_vx <= prod_t'(quat_w) * prod_t'(vec_x);
      qy_vz <= prod_t'(quat_y) * prod_t'(vec_z);
      qz_vy <= prod_t'(quat_z) * prod_t'(vec_y);
      qw_vy <= prod_t'(quat_w) * prod_t'(vec_y);
      qx_vz <= prod_t'(quat_x) * prod_t'(vec_z);
      qz_vx <= prod_t'(quat_z) * prod_t'(vec_x);
      qw_vz <= prod_t'(quat_w) * prod_t'(vec_z);
      qx_vy <= prod_t'(quat_x) * prod_t'(vec_y);
      qy_vx <= prod_t'(quat_y) * prod_t'(vec_x);

      // Stage 2
      q2 <= q1;
      pw <= -psum_t'(qx_vx) - psum_t'(qy_vy) - psum_t'(qz_vz);
      px <=  psum_t'(qw_vx) + psum_t'(qy_vz) - psum_t'(qz_vy);
      py <=  psum_t'(qw_vy) - psum_t'(qx_vz) + psum_t'(qz_vx);
      pz <=  psum_t'(qw_vz) + psum_t'(qx_vy) - psum_t'(qy_vx);

      // Stage 3
      pw_qx <= rprd_t'(pw) * rprd_t'(q2.x);
      px_qw <= rprd_t'(px) * rprd_t'(q2.w);
      py_qz <= rprd_t'(py) * rprd_t'(q2.z);
      pz_qy <= rprd_t'(pz) * rprd_t'(q2.y);
      pw_qy <= rprd_t'(pw) * rprd_t'(q2.y);
      px_qz <= rprd_t'(px) * rprd_t'(q2.z);
      py_qw <= rprd_t'(py) * rprd_t'(q2.w);
      pz_qx <= rprd_t'(pz) * rprd_t'(q2.x);
      pw_qz <= rprd_t'(pw) * rprd_t'(q2.z);
      px_qy <= rprd_t'(px) * rprd_t'(q2.y);
      py_qx <= rprd_t'(py) * rprd_t'(q2.x);
      pz_qw <= rprd_t'(pz) * rprd_t'(q2.w);

      // Stage 4
      rx <= -rsum_t'(pw_qx) + rsum_t'(px_qw) - rsum_t'(py_qz) + rsum_t'(pz_qy);
      ry <= -rsum_t'(pw_qy) + rsum_t'(px_qz) + rsum_t'(py_qw) - rsum_t'(pz_qx);
      rz <= -rsum_t'(pw_qz) - rsum_t'(px_qy) + rsum_t'(py_qx) + rsum_t'(pz_qw);

      // Stage 5: output register
      out_x   <= res_x;
      out_y   <= res_y;
      out_z   <= res_z;
      clipped <= sat_x | sat_y | sat_z;
    end
  end

endmodule
